// ===== src/klrx_pkg.sv =====
// ----------------------------------------------------------------------------
// K-line response frame receiver package
// Shared types, status codes and constants for the frame receiver.
// ----------------------------------------------------------------------------
package klrx_pkg;

  // Framing constants.
  localparam logic [7:0] StartA     = 8'h80;
  localparam logic [7:0] StartB     = 8'h81;
  localparam logic [8:0] LenOffset  = 9'd5;
  localparam logic [8:0] LenUnknown = 9'd255;

  // Default tick counter width.
  localparam int unsigned TickCountBitsDef = 16;

  // Configuration register reset values.
  localparam logic [7:0]  TesterAddrRst = 8'hF1;
  localparam logic [8:0]  MaxFrameRst   = 9'd260;
  localparam logic [15:0] TimeoutRst    = 16'd5000;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgTesterAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFrame   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Request types.
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_STORED   = 3'd1,
    ST_DONE     = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_ECHO     = 3'd5,
    ST_RESTART  = 3'd6
  } status_e;

  // Configuration seen by the frame decoder.
  typedef struct packed {
    logic [7:0]  tester_address;
    logic [8:0]  max_frame_bytes;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One result as produced by the frame decoder.
  typedef struct packed {
    status_e    status;
    logic [7:0] frame_byte;
    logic [8:0] byte_position;
    logic       frame_last;
  } result_t;

  // True for either start byte.
  function automatic logic is_start(input logic [7:0] b);
    return (b == StartA) || (b == StartB);
  endfunction

endpackage

// ===== src/klrx_if.sv =====
// ----------------------------------------------------------------------------
// K-line receiver channel interfaces
// Request channel (byte or tick) and response channel with valid/ready.
// ----------------------------------------------------------------------------
interface klrx_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface klrx_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame_byte;
  logic [8:0] byte_position;
  logic       frame_last;

  modport source (output valid, output status, output frame_byte,
                  output byte_position, output frame_last, input ready);
  modport sink   (input valid, input status, input frame_byte,
                  input byte_position, input frame_last, output ready);
endinterface

// ===== src/kline_response_frame_receiver.sv =====
// A result is registered and shown in the cycle after its request is taken.
// Throughput: one request (byte or tick) per cycle; the output register lets a
// new request in whenever the held result is taken or the register is empty.
// Reset: asynchronous, active low; clears frame state, tick counter, output
// valid, and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// K-line response frame receiver
// Top level: configuration registers, frame decoder and result register.
// ----------------------------------------------------------------------------
module kline_response_frame_receiver import klrx_pkg::*; #(
  parameter int unsigned TICK_COUNT_BITS = TickCountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  klrx_req_if.sink            req,
  klrx_rsp_if.source          rsp,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  result_t result;
  result_t rsp_q;
  logic    rsp_valid_q;
  logic    accept;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tester_address  <= TesterAddrRst;
      cfg_q.max_frame_bytes <= MaxFrameRst;
      cfg_q.timeout_ticks   <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTesterAddr: cfg_q.tester_address  <= cfg_data_i[7:0];
        CfgMaxFrame:   cfg_q.max_frame_bytes <= cfg_data_i[8:0];
        CfgTimeout:    cfg_q.timeout_ticks   <= cfg_data_i[15:0];
        default:       ;
      endcase
    end
  end

  // A request is taken whenever the result register is free or being emptied.
  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;

  klrx_core #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req.req_type),
    .rx_byte_i  (req.rx_byte),
    .cfg_i      (cfg_q),
    .result_o   (result)
  );

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req.ready) begin
      rsp_valid_q <= req.valid;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= result;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.status        = rsp_q.status;
  assign rsp.frame_byte    = rsp_q.frame_byte;
  assign rsp.byte_position = rsp_q.byte_position;
  assign rsp.frame_last    = rsp_q.frame_last;

  // The last-byte flag goes with frame completion and nothing else.
  a_last_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.frame_last == (rsp.status == ST_DONE)))
    else $error("frame_last does not match completion status");

  // Results without a stored byte carry zero byte and position.
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status != ST_STORED && rsp.status != ST_DONE &&
     rsp.status != ST_RESTART) |-> (rsp.frame_byte == 8'd0 &&
                                    rsp.byte_position == 9'd0))
    else $error("nonzero payload on a result without a stored byte");

  // A restart is always reported as the first byte of a frame.
  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status == ST_RESTART) |-> (rsp.byte_position == 9'd0 &&
      (rsp.frame_byte == StartA || rsp.frame_byte == StartB)))
    else $error("restart result not at position zero with a start byte");

  // A tick never yields a stored byte.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.req_type == ReqTick) |=>
      (rsp.status == ST_NONE || rsp.status == ST_TIMEOUT))
    else $error("tick request produced a byte result");

endmodule

// ===== src/klrx_core.sv =====
// ----------------------------------------------------------------------------
// K-line frame decoder
// Holds the frame state and decodes one byte or tick per accepted request.
// ----------------------------------------------------------------------------
module klrx_core import klrx_pkg::*; #(
  parameter int unsigned TICK_COUNT_BITS = TickCountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int unsigned CmpW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
  localparam logic [TICK_COUNT_BITS-1:0] GapMax = '1;

  logic [8:0]                 next_pos_q, next_pos_d;
  logic [8:0]                 exp_len_q, exp_len_d;
  logic [7:0]                 format_q, format_d;
  logic [TICK_COUNT_BITS-1:0] gap_q, gap_d;

  logic [TICK_COUNT_BITS-1:0] gap_inc;
  logic [8:0]                 len_80;
  logic [8:0]                 len_eff;
  logic [9:0]                 pos_plus;

  // Tick counter step and the length arithmetic for the current byte.
  always_comb begin
    gap_inc  = (gap_q == GapMax) ? gap_q : gap_q + 1'b1;
    len_80   = {1'b0, rx_byte_i} + LenOffset;
    pos_plus = {1'b0, next_pos_q} + 10'd1;
    if (next_pos_q == 9'd3) begin
      len_eff = (format_q == StartA) ? len_80 : LenOffset;
    end else begin
      len_eff = exp_len_q;
    end
  end

  // Frame decode: next state and result for one request.
  always_comb begin
    next_pos_d = next_pos_q;
    exp_len_d  = exp_len_q;
    format_d   = format_q;
    gap_d      = gap_q;
    result_o   = '{status: ST_NONE, frame_byte: 8'd0, byte_position: 9'd0,
                   frame_last: 1'b0};

    if (req_type_i == ReqTick) begin
      // Count the gap; a gap reaching the timeout abandons the frame.
      if (CmpW'(gap_inc) >= CmpW'(cfg_i.timeout_ticks)) begin
        gap_d           = '0;
        next_pos_d      = 9'd0;
        exp_len_d       = LenUnknown;
        result_o.status = ST_TIMEOUT;
      end else begin
        gap_d = gap_inc;
      end
    end else begin
      gap_d = '0;
      if (next_pos_q == 9'd0) begin
        // Hunting for a start byte.
        if (is_start(rx_byte_i)) begin
          format_d   = rx_byte_i;
          next_pos_d = 9'd1;
          result_o   = '{status: ST_STORED, frame_byte: rx_byte_i,
                         byte_position: 9'd0, frame_last: 1'b0};
        end
      end else if (next_pos_q == 9'd1 && rx_byte_i != cfg_i.tester_address) begin
        // Echo check failed; a start byte restarts the frame.
        if (is_start(rx_byte_i)) begin
          format_d   = rx_byte_i;
          next_pos_d = 9'd1;
          result_o   = '{status: ST_RESTART, frame_byte: rx_byte_i,
                         byte_position: 9'd0, frame_last: 1'b0};
        end else begin
          next_pos_d      = 9'd0;
          result_o.status = ST_ECHO;
        end
      end else if (next_pos_q == 9'd3 && format_q == StartA &&
                   len_80 > cfg_i.max_frame_bytes) begin
        // Declared length too large for the configured maximum.
        next_pos_d      = 9'd0;
        exp_len_d       = LenUnknown;
        result_o.status = ST_OVERFLOW;
      end else if (pos_plus >= {1'b0, len_eff}) begin
        // Last byte of the frame.
        next_pos_d = 9'd0;
        exp_len_d  = LenUnknown;
        result_o   = '{status: ST_DONE, frame_byte: rx_byte_i,
                       byte_position: next_pos_q, frame_last: 1'b1};
      end else begin
        next_pos_d = pos_plus[8:0];
        exp_len_d  = len_eff;
        result_o   = '{status: ST_STORED, frame_byte: rx_byte_i,
                       byte_position: next_pos_q, frame_last: 1'b0};
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_pos_q <= 9'd0;
      exp_len_q  <= LenUnknown;
      format_q   <= 8'd0;
      gap_q      <= '0;
    end else if (accept_i) begin
      next_pos_q <= next_pos_d;
      exp_len_q  <= exp_len_d;
      format_q   <= format_d;
      gap_q      <= gap_d;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// K-line response frame receiver testbench
// Drives bytes and ticks into the receiver and checks every result. The
// expected results come from a cycle-free model of the frame decoder. The run
// starts with short directed sequences under several register settings. Random
// frames, broken frames, line noise and tick bursts follow. Both channels
// stall at random in two idling mixes, then run with no idling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import klrx_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  // Frame decoder model with a queue of the results it still expects.
  class frame_checker;
    logic [7:0]  addr;
    logic [8:0]  max_len;
    logic [15:0] tmo;
    logic [8:0]  next_pos;
    logic [8:0]  frame_len;
    logic [7:0]  fmt;
    logic [15:0] gap;
    result_t     expected_q[$];
    int unsigned errors;

    function new();
      addr      = TesterAddrRst;
      max_len   = MaxFrameRst;
      tmo       = TimeoutRst;
      next_pos  = '0;
      frame_len = LenUnknown;
      fmt       = '0;
      gap       = '0;
      errors    = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgTesterAddr: addr = data[7:0];
        CfgMaxFrame:   max_len = data[8:0];
        CfgTimeout:    tmo = data[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Works out the result of one request and advances the frame state.
    function result_t decode_request(logic kind, logic [7:0] value);
      result_t    r;
      logic [8:0] pos;
      logic [8:0] len;
      r = '0;
      r.status = ST_NONE;
      if (kind == ReqTick) begin
        if (gap != 16'hFFFF) gap = gap + 16'd1;
        if (gap >= tmo) begin
          gap = '0;
          next_pos = '0;
          frame_len = LenUnknown;
          r.status = ST_TIMEOUT;
        end
        return r;
      end
      gap = '0;
      pos = next_pos;
      // Hunting for a start byte.
      if (pos == 9'd0) begin
        if (value != StartA && value != StartB) return r;
        fmt = value;
        next_pos = 9'd1;
        r.status = ST_STORED;
        r.frame_byte = value;
        return r;
      end
      // Address byte that does not match: restart on a start byte, else drop.
      if (pos == 9'd1 && value != addr) begin
        if (value == StartA || value == StartB) begin
          fmt = value;
          next_pos = 9'd1;
          r.status = ST_RESTART;
          r.frame_byte = value;
          return r;
        end
        next_pos = '0;
        r.status = ST_ECHO;
        return r;
      end
      // Length byte: only the long format carries a length and is checked.
      if (pos == 9'd3) begin
        if (fmt == StartA) begin
          len = {1'b0, value} + LenOffset;
          if (len > max_len) begin
            next_pos = '0;
            frame_len = LenUnknown;
            r.status = ST_OVERFLOW;
            return r;
          end
          frame_len = len;
        end else begin
          frame_len = LenOffset;
        end
      end
      r.frame_byte = value;
      r.byte_position = pos;
      if ({1'b0, pos} + 10'd1 >= {1'b0, frame_len}) begin
        next_pos = '0;
        frame_len = LenUnknown;
        r.status = ST_DONE;
        r.frame_last = 1'b1;
        return r;
      end
      next_pos = pos + 9'd1;
      r.status = ST_STORED;
      return r;
    endfunction

    function void note_request(logic kind, logic [7:0] value);
      expected_q.push_back(decode_request(kind, value));
    endfunction

    function void flag(string what, logic [8:0] want, logic [8:0] seen);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
      errors++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) flag("status", 9'(want.status), 9'(got.status));
      if (got.frame_byte !== want.frame_byte) flag("frame_byte", 9'(want.frame_byte),
                                                   9'(got.frame_byte));
      if (got.byte_position !== want.byte_position) flag("byte_position",
                                                         want.byte_position,
                                                         got.byte_position);
      if (got.frame_last !== want.frame_last) flag("frame_last", 9'(want.frame_last),
                                                   9'(got.frame_last));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  klrx_req_if req_ch ();
  klrx_rsp_if rsp_ch ();

  frame_checker book;
  result_t      rsp_seen;
  int unsigned  src_idle_pct = 6;
  int unsigned  snk_idle_pct = 70;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  logic [7:0]   cur_addr = TesterAddrRst;
  logic [8:0]   cur_max = MaxFrameRst;
  logic [15:0]  cur_tmo = TimeoutRst;

  kline_response_frame_receiver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver side stalls at random.
  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Accepted requests feed the model before results of the same edge are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) book.note_request(req_ch.req_type, req_ch.rx_byte);
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen.status = status_e'(rsp_ch.status);
        rsp_seen.frame_byte = rsp_ch.frame_byte;
        rsp_seen.byte_position = rsp_ch.byte_position;
        rsp_seen.frame_last = rsp_ch.frame_last;
        book.check_result(rsp_seen);
      end
    end
  end

  // Offers one request, with random idle cycles first, and waits for acceptance.
  task automatic send_request(input logic kind, input logic [7:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte <= value;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_tick();
    send_request(ReqTick, 8'($urandom_range(255)));
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.set_register(idx, data);
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] a, input logic [8:0] m, input logic [15:0] t);
    write_cfg(CfgTesterAddr, 16'(a));
    write_cfg(CfgMaxFrame, 16'(m));
    write_cfg(CfgTimeout, t);
    cur_addr = a;
    cur_max = m;
    cur_tmo = t;
  endtask

  // Sends a frame byte, sometimes after a burst of ticks that may hit the timeout.
  task automatic send_data(input logic [7:0] value);
    int unsigned cap;
    int unsigned n;
    cap = (cur_tmo > 16'd12 || cur_tmo == 16'd0) ? 12 : int'(cur_tmo);
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(cap, 1);
      repeat (n) send_tick();
    end
    send_request(ReqByte, value);
  endtask

  // One frame with random content; a few have a wrong address byte.
  task automatic send_frame();
    logic [7:0]  fmt;
    logic [7:0]  lenb;
    int unsigned pick;
    int unsigned total;
    fmt = $urandom_range(1) ? StartB : StartA;
    send_data(fmt);
    pick = $urandom_range(9);
    if (pick == 0) begin
      send_data(8'($urandom_range(255)));
      return;
    end
    if (pick == 1) begin
      send_data($urandom_range(1) ? StartA : StartB);
      return;
    end
    send_data(cur_addr);
    send_data(8'($urandom_range(255)));
    pick = $urandom_range(19);
    if (pick < 14) begin
      lenb = 8'($urandom_range(6));
    end else if (pick < 18 && cur_max >= 9'd5) begin
      // Right at the length limit, or one above it.
      total = int'(cur_max) - 5 + $urandom_range(1);
      lenb = (total > 255) ? 8'd255 : 8'(total);
    end else begin
      lenb = 8'($urandom_range(255));
    end
    send_data(lenb);
    if (fmt == StartA) begin
      total = int'(lenb) + 5;
      if (total > int'(cur_max)) total = 4;
    end else begin
      total = 5;
    end
    for (int unsigned i = 4; i < total; i++) send_data(8'($urandom_range(255)));
  endtask

  // Mostly frames, some line noise, with a full pause halfway through.
  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    bit          paused;
    stop_at = items_sent + budget;
    paused = 1'b0;
    while (items_sent < stop_at) begin
      if (!paused && items_sent + budget / 2 >= stop_at) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 2) wait_drained();
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_tick();
        else send_request(ReqByte, 8'($urandom_range(255)));
      end else begin
        send_frame();
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgTesterAddr;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = ReqByte;
    req_ch.rx_byte = '0;
    rsp_ch.ready = 1'b0;
    book = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: noise while hunting, a dropped echo, a restart on a start
    // byte in the address slot, and a short-format frame whose length byte is
    // ignored.
    send_request(ReqByte, 8'h00);
    send_tick();
    send_request(ReqByte, StartB);
    send_request(ReqByte, 8'h55);
    send_request(ReqByte, StartA);
    send_request(ReqByte, StartB);
    send_request(ReqByte, 8'hF1);
    send_request(ReqByte, 8'hFF);
    send_request(ReqByte, 8'h7F);
    send_request(ReqByte, 8'hAA);
    send_request(ReqByte, 8'hBB);
    wait_drained();

    // Smallest legal maximum and timeout: one overflow, a timeout, then a
    // frame of exactly the maximum length.
    configure(8'h00, 9'd5, 16'd1);
    send_request(ReqByte, StartA);
    send_request(ReqByte, 8'h00);
    send_request(ReqByte, 8'h00);
    send_request(ReqByte, 8'h01);
    send_tick();
    send_request(ReqByte, StartA);
    send_request(ReqByte, 8'h00);
    send_request(ReqByte, 8'h00);
    send_request(ReqByte, 8'h00);
    send_request(ReqByte, 8'h33);
    wait_drained();

    // Maximum below five overflows every long-format frame; a zero timeout
    // fires on every tick.
    configure(8'hFF, 9'd3, 16'd0);
    send_request(ReqByte, StartA);
    send_request(ReqByte, 8'hFF);
    send_request(ReqByte, 8'h12);
    send_request(ReqByte, 8'h00);
    send_tick();
    wait_drained();

    configure(8'($urandom_range(255)), 9'd260, 16'd8);
    run_random(170);

    src_idle_pct = 70;
    snk_idle_pct = 6;
    configure(8'($urandom_range(255)), 9'd260 - 9'd260 + 9'($urandom_range(40, 5)), 16'd3);
    run_random(170);

    // Largest timeout: a frame start followed by a run of ticks that stays far
    // below the limit.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    configure(8'($urandom_range(255)), 9'd511, 16'hFFFF);
    send_request(ReqByte, StartA);
    repeat (16) send_tick();
    run_random(170);

    repeat (4) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/klrx_pkg.sv
src/klrx_if.sv
src/klrx_core.sv
src/kline_response_frame_receiver.sv
tb/sv/tb_top.sv
